@@ rtl/sliding_log_rate_limiter_macros.svh @@
// ----------------------------------------------------------------------------
// sliding log rate limiter assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SLIDING_LOG_RATE_LIMITER_MACROS_SVH
`define SLIDING_LOG_RATE_LIMITER_MACROS_SVH

// property checked only outside reset
`define SLR_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property that also covers the reset cycles
`define SLR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/slr_pkg.sv @@
// ----------------------------------------------------------------------------
// slr_pkg
// shared constants and codes of the sliding log rate limiter
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int SLOTS_DEFAULT = 8;

    localparam int TS_W      = 32;
    localparam int LEN_W     = 13;
    localparam int WINDOW_W  = 31;
    localparam int LIMIT_W   = 4;
    localparam int VERDICT_W = 2;
    localparam int COUNT_W   = 4;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;

    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam verdict_t VERDICT_FORWARD      = 2'd0;
    localparam verdict_t VERDICT_IGNORED      = 2'd1;
    localparam verdict_t VERDICT_TOO_LONG     = 2'd2;
    localparam verdict_t VERDICT_RATE_LIMITED = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TICKS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PER_WINDOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MESSAGE_BYTES = 2'd2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd10000;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd8;
    localparam logic [LEN_W-1:0]    BYTES_RESET  = 13'd1024;

endpackage

@@ rtl/sliding_log_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// sliding_log_rate_limiter
// admission filter keeping a ring of accepted timestamps in a small memory
// ----------------------------------------------------------------------------
// Input requests arrive on s_tvalid/s_tready: s_tdata carries the timestamp
// and message length, s_tuser the text and control flags. Each request gives
// exactly one result request on m_tvalid/m_tready: m_tuser holds the verdict
// and m_tdata the number of timestamps held afterwards.
// One request is handled at a time. Ignored and over-long messages go from
// acceptance straight to the output stage; checked messages first drop the
// expired stamps, one per cycle, as the oldest stamp is read from the ring
// memory through a registered read port, and then take their verdict.
// The next request is accepted in the cycle after the result is loaded into
// the output register, so a result may still wait while a new request enters.
// If the receiver stalls, the result holds in the output register and a
// following result waits in the sequencer until the register frees.
// Reset (aresetn low, synchronous) empties the ring, restores the register
// defaults and drops any pending result; ring contents need no clearing.
// Configuration writes on cfg_valid/cfg_ready are always taken.
// ----------------------------------------------------------------------------
module sliding_log_rate_limiter #(
    parameter int SLOTS = slr_pkg::SLOTS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: timestamp[31:0], message_length[44:32], zero pad
    input  logic [slr_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: is_text[0], is_control[1]
    input  logic [slr_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: in_window[3:0], zero pad
    output logic [slr_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: verdict[1:0]
    output logic [slr_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [slr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [slr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import slr_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int SUM_W = IDX_W + 2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [WINDOW_W-1:0] window_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LEN_W-1:0]    bytes_reg;
    logic [IDX_W-1:0]    oldest_reg, oldest_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [TS_W-1:0]     ts_reg, ts_next;
    verdict_t            res_verdict_reg, res_verdict_next;
    logic [CNT_W-1:0]    res_count_reg, res_count_next;
    logic                out_valid_reg, out_valid_next;
    verdict_t            out_verdict_reg, out_verdict_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic [TS_W-1:0]     stamp_mem [SLOTS];
    logic [TS_W-1:0]     rd_data_reg;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;

    logic                in_accept;
    logic [TS_W-1:0]     in_ts;
    logic [LEN_W-1:0]    in_len;
    logic                in_text;
    logic                in_control;
    logic [TS_W-1:0]     age;
    logic                expired;
    logic [SUM_W-1:0]    inc_sum;
    logic [SUM_W-1:0]    tail_sum;
    logic [IDX_W-1:0]    oldest_inc;
    logic [CMP_W-1:0]    held_ext;
    logic [CMP_W-1:0]    limit_ext;
    logic [CMP_W-1:0]    res_count_ext;
    logic                out_free;

    assign in_ts      = s_tdata[TS_W-1:0];
    assign in_len     = s_tdata[TS_W+LEN_W-1:TS_W];
    assign in_text    = s_tuser[0];
    assign in_control = s_tuser[1];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    // ring pointer arithmetic, modulo the slot count
    always_comb begin
        inc_sum = SUM_W'(oldest_reg) + SUM_W'(1);
        if (inc_sum >= SUM_W'(SLOTS)) begin
            inc_sum = inc_sum - SUM_W'(SLOTS);
        end
        oldest_inc = inc_sum[IDX_W-1:0];
        tail_sum = SUM_W'(oldest_reg) + SUM_W'(held_reg);
        if (tail_sum >= SUM_W'(SLOTS)) begin
            tail_sum = tail_sum - SUM_W'(SLOTS);
        end
        wr_addr = tail_sum[IDX_W-1:0];
    end

    assign age      = ts_reg - rd_data_reg;
    assign expired  = (held_reg != '0) && (age > {1'b0, window_reg});
    assign held_ext = CMP_W'(held_reg);
    assign limit_ext = (CMP_W'(limit_reg) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS)
                                                            : CMP_W'(limit_reg);
    assign res_count_ext = CMP_W'(res_count_reg);

    always_comb begin
        state_next       = state_reg;
        oldest_next      = oldest_reg;
        held_next        = held_reg;
        ts_next          = ts_reg;
        res_verdict_next = res_verdict_reg;
        res_count_next   = res_count_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_verdict_next = out_verdict_reg;
        out_count_next   = out_count_reg;
        wr_en            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    ts_next        = in_ts;
                    res_count_next = held_reg;
                    if (!in_text || in_control) begin
                        res_verdict_next = VERDICT_IGNORED;
                        state_next       = ST_OUT;
                    end else if (in_len > bytes_reg) begin
                        res_verdict_next = VERDICT_TOO_LONG;
                        state_next       = ST_OUT;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (expired) begin
                    // drop the oldest stamp; its successor is read next cycle
                    oldest_next = oldest_inc;
                    held_next   = held_reg - CNT_W'(1);
                end else if (held_ext >= limit_ext) begin
                    res_verdict_next = VERDICT_RATE_LIMITED;
                    res_count_next   = held_reg;
                    state_next       = ST_OUT;
                end else begin
                    wr_en            = 1'b1;
                    held_next        = held_reg + CNT_W'(1);
                    res_verdict_next = VERDICT_FORWARD;
                    res_count_next   = held_reg + CNT_W'(1);
                    state_next       = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = res_verdict_reg;
                    out_count_next   = res_count_ext[COUNT_W-1:0];
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ring memory: one write port, one registered read at the next oldest slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stamp_mem[wr_addr] <= ts_reg;
        end
        rd_data_reg <= stamp_mem[oldest_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            window_reg    <= WINDOW_RESET;
            limit_reg     <= LIMIT_RESET;
            bytes_reg     <= BYTES_RESET;
        end else begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_WINDOW_TICKS:      window_reg <= cfg_data[WINDOW_W-1:0];
                    CFG_MAX_PER_WINDOW:    limit_reg  <= cfg_data[LIMIT_W-1:0];
                    CFG_MAX_MESSAGE_BYTES: bytes_reg  <= cfg_data[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ts_reg          <= ts_next;
        res_verdict_reg <= res_verdict_next;
        res_count_reg   <= res_count_next;
        out_verdict_reg <= out_verdict_next;
        out_count_reg   <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_verdict_reg;
    assign m_tdata  = {{(M_TDATA_W-COUNT_W){1'b0}}, out_count_reg};

endmodule

@@ rtl/slr_checker.sv @@
// ----------------------------------------------------------------------------
// slr_checker
// port-level assertions for the sliding log rate limiter, bound to the top
// ----------------------------------------------------------------------------
`include "sliding_log_rate_limiter_macros.svh"

module slr_checker #(
    parameter int SLOTS = slr_pkg::SLOTS_DEFAULT
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [slr_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [slr_pkg::M_TUSER_W-1:0]   m_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import slr_pkg::*;

    // stalled result holds its value
    `SLR_ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // one request in flight: accepting blocks the next acceptance
    `SLR_ASSERT_CLK(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "request accepted while another is in flight")

    // a forwarded message is always counted in the window (checked for SLOTS below 16)
    `SLR_ASSERT_CLK(a_fwd_counted, aclk, aresetn, m_tvalid && (m_tuser == VERDICT_FORWARD) && (SLOTS < 16) |-> m_tdata[3:0] != 4'd0, "forwarded result with an empty window")

    // the count never exceeds the ring capacity (checked for SLOTS below 16)
    `SLR_ASSERT_CLK(a_count_bound, aclk, aresetn, m_tvalid && (SLOTS < 16) |-> 32'(m_tdata[3:0]) <= 32'(SLOTS), "window count above capacity")

    // reset drops any pending result
    `SLR_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind sliding_log_rate_limiter slr_checker #(.SLOTS(SLOTS)) u_slr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
